// File: sv/sai_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted array insert block.
// No dependencies; every other file of the block uses this package.
package sai_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_INSERT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_UNSORTED = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_INSERT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_CMP,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

endpackage

// File: sv/sai_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the operation and result streams.
// Depends on sai_pkg for the value width.
interface sai_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic signed [sai_pkg::VAL_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink (input valid, op, value, output ready);
endinterface

interface sai_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sai_pkg::VAL_W-1:0] element;
  logic [1:0]                       status;
  logic                             last;

  modport source (output valid, element, status, last, input ready);
  modport sink (input valid, element, status, last, output ready);
endinterface

// File: sv/sorted_array_insert_core.sv
`timescale 1ns / 1ps
// Top level of the sorted array insert block: front end, command queue, back end.
// Depends on sai_pkg, sai_if, sai_front and sai_back.
//
// The block keeps up to 32 signed 32-bit elements in a single-port store with
// a registered read. Clear and append give no result; an append to a full
// store is dropped, and an append below the previous element marks the store
// unsorted. An insert into a sorted store that is not full walks down from the
// top, reading each element and then comparing and writing it one slot up,
// places the value ahead of any equal elements, then emits the whole new array
// one element at a time with last on the final one. An insert into an
// unsorted or full store gives one error result (element 0, last set) and
// changes nothing.
// A two-entry command queue sits between the front end and the sequencer, and
// the result register lets the sequencer run on while a transfer is pending.
module sorted_array_insert_core (
  input  logic       clk,
  input  logic       rst,
  sai_in_if.sink     items,
  sai_out_if.source  results
);
  import sai_pkg::*;

  // Queue head handed from the front end to the sequencer
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  sai_front u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // Hold the head command until its work is done, then advance the queue
  sai_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

// File: sv/sai_front.sv
`timescale 1ns / 1ps
// Front end: accepts operations, decodes them and queues commands.
// Depends on sai_pkg and sai_in_if.
module sai_front (
  input  logic         clk,
  input  logic         rst,
  sai_in_if.sink       items,
  output logic         q_valid,
  output sai_pkg::cmd_t q_cmd,
  input  logic         q_pop
);
  import sai_pkg::*;

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       known_op;
  logic       push;
  cmd_t       dec;

  // Decode the op code; the unused code is taken and dropped
  always_comb begin
    known_op  = 1'b1;
    dec.value = items.value;
    dec.kind  = CMD_CLEAR;
    case (items.op)
      OP_CLEAR:  dec.kind = CMD_CLEAR;
      OP_APPEND: dec.kind = CMD_APPEND;
      OP_INSERT: dec.kind = CMD_INSERT;
      default:   known_op = 1'b0;
    endcase
  end

  assign items.ready = (fill != 2'd2);
  assign push        = items.valid && items.ready && known_op;
  assign q_valid     = (fill != 2'd0);
  assign q_cmd       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: sv/sai_back.sv
`timescale 1ns / 1ps
// Back end: element store, shift and emit sequencer, result register.
// Depends on sai_pkg and sai_out_if.
module sai_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  sai_pkg::cmd_t q_cmd,
  output logic          q_pop,
  sai_out_if.source     results
);
  import sai_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic                    mem_re;
  logic [IDX_W-1:0]        mem_raddr;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic                    unsorted, unsorted_next;
  logic signed [VAL_W-1:0] last_val, last_val_next;
  logic [CNT_W-1:0]        idx, idx_next;

  logic                    out_valid;
  logic signed [VAL_W-1:0] out_element;
  status_t                 out_status;
  logic                    out_last;
  logic                    out_free;
  logic                    load_out;
  logic signed [VAL_W-1:0] load_element;
  status_t                 load_status;
  logic                    load_last;
  logic                    place;
  logic                    is_full;

  assign out_free = !out_valid || results.ready;
  assign is_full  = (count == CNT_W'(DEPTH));

  always_comb begin
    state_next    = state;
    count_next    = count;
    unsorted_next = unsorted;
    last_val_next = last_val;
    idx_next      = idx;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx[IDX_W-1:0];
    mem_wdata     = q_cmd.value;
    mem_re        = 1'b0;
    mem_raddr     = idx[IDX_W-1:0];
    load_out      = 1'b0;
    load_element  = '0;
    load_status   = STAT_OK;
    load_last     = 1'b1;
    place         = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            CMD_CLEAR: begin
              count_next    = '0;
              unsorted_next = 1'b0;
              q_pop         = 1'b1;
            end
            CMD_APPEND: begin
              q_pop = 1'b1;
              if (!is_full) begin
                mem_we        = 1'b1;
                mem_waddr     = count[IDX_W-1:0];
                count_next    = count + CNT_W'(1);
                last_val_next = q_cmd.value;
                if (count != '0 && last_val > q_cmd.value) begin
                  unsorted_next = 1'b1;
                end
              end
            end
            CMD_INSERT: begin
              if (unsorted || is_full) begin
                if (out_free) begin
                  load_out    = 1'b1;
                  load_status = unsorted ? STAT_UNSORTED : STAT_FULL;
                  q_pop       = 1'b1;
                end
              end else begin
                idx_next   = count;
                state_next = S_SHIFT_RD;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (idx == '0) begin
          place = 1'b1;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = IDX_W'(idx - CNT_W'(1));
          state_next = S_SHIFT_CMP;
        end
      end
      S_SHIFT_CMP: begin
        if (rd_data >= q_cmd.value) begin
          mem_we     = 1'b1;
          mem_wdata  = rd_data;
          idx_next   = idx - CNT_W'(1);
          state_next = S_SHIFT_RD;
        end else begin
          place = 1'b1;
        end
      end
      S_EMIT_RD: begin
        mem_re     = 1'b1;
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          load_out     = 1'b1;
          load_element = rd_data;
          load_last    = (idx + CNT_W'(1) == count);
          if (load_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + CNT_W'(1);
            state_next = S_EMIT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Drop the new value into its slot, retire the command, start the run
    if (place) begin
      mem_we     = 1'b1;
      mem_wdata  = q_cmd.value;
      count_next = count + CNT_W'(1);
      q_pop      = 1'b1;
      idx_next   = '0;
      state_next = S_EMIT_RD;
      if (count == '0 || q_cmd.value > last_val) begin
        last_val_next = q_cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      unsorted <= 1'b0;
      idx      <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      unsorted <= unsorted_next;
      idx      <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    last_val <= last_val_next;
    if (load_out) begin
      out_element <= load_element;
      out_status  <= load_status;
      out_last    <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid   = out_valid;
  assign results.element = out_element;
  assign results.status  = out_status;
  assign results.last    = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count above store depth");

  a_shift_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_RD || state == S_SHIFT_CMP) |-> (count < CNT_W'(DEPTH) && !unsorted))
    else $error("shift running on a full or unsorted store");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != STAT_OK) |-> out_last)
    else $error("error result not marked last");

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD || state == S_EMIT_OUT) |-> idx < count)
    else $error("emit index past element count");

endmodule
